@@ src/stbs_pkg.sv @@
package stbs_pkg;

  // Field widths of the stream words.
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;
  localparam int OUT_TDATA_W = 16;

  // Command codes carried in s_tuser.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOWER  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UPPER  = 2'd3;

  // One accepted input word as it waits in the command queue.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } stbs_word_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic       valid;
    stbs_word_t word;
  } stbs_head_t;

endpackage

@@ src/stbs_ram.sv @@
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/stbs_front.sv @@
module stbs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [stbs_pkg::VALUE_W-1:0]  s_tdata,
  input  logic [stbs_pkg::CMD_W-1:0]    s_tuser,
  output stbs_pkg::stbs_head_t          head,
  input  logic                          pop
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  stbs_pkg::stbs_word_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             take;

  assign s_tready = (fill != (PTR_W+1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign take     = pop && head.valid;

  // The oldest word is offered to the back end.
  assign head.valid = (fill != '0);
  assign head.word  = slots[rd_ptr];

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].command <= s_tuser;
      slots[wr_ptr].value   <= s_tdata;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (take && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ src/stbs_back.sv @@
module stbs_back #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stbs_pkg::stbs_head_t          head,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [stbs_pkg::POS_W-1:0]    m_position
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic signed [stbs_pkg::VALUE_W-1:0] target;
  logic          upper;

  logic [CW-1:0] mid;
  logic [CW-1:0] lo_step;
  logic [CW-1:0] hi_step;
  logic [CW-1:0] mid_step;
  logic [CW-1:0] start_mid;
  logic          go_right;
  logic          more;
  logic          slot_free;
  logic          ram_we;
  logic [AW-1:0] raddr;
  logic [stbs_pkg::VALUE_W-1:0] rdata;
  logic signed [stbs_pkg::VALUE_W-1:0] probe;
  logic          load_search;
  logic          load_hold;

  stbs_ram #(
    .WIDTH (stbs_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (head.word.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Words are taken from the queue only between searches.
  assign pop       = (state == ST_IDLE) && head.valid;
  assign ram_we    = pop && (head.word.command == stbs_pkg::CMD_APPEND) && (count < DEPTH_CNT);
  assign slot_free = !m_tvalid || m_tready;

  // One probe per cycle: the word read for the current midpoint decides
  // the next half, whose midpoint is read in the same cycle.
  assign probe     = $signed(rdata);
  assign mid       = lo + ((hi - lo) >> 1);
  assign go_right  = upper ? !(target < probe) : (probe < target);
  assign lo_step   = go_right ? mid + CW'(1) : lo;
  assign hi_step   = go_right ? hi : mid;
  assign more      = lo_step < hi_step;
  assign mid_step  = lo_step + ((hi_step - lo_step) >> 1);
  assign start_mid = count >> 1;
  assign raddr     = (state == ST_SEARCH) ? mid_step[AW-1:0] : start_mid[AW-1:0];

  assign load_search = (state == ST_SEARCH) && !more && slot_free;
  assign load_hold   = (state == ST_HOLD) && slot_free;

  // Result register toward the output stream.
  always_ff @(posedge clk) begin
    if (load_search) begin
      m_position <= stbs_pkg::POS_W'(lo_step);
    end else if (load_hold) begin
      m_position <= stbs_pkg::POS_W'(lo);
    end
  end

  // Command execution and search sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_search || load_hold) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (head.word.command)
              stbs_pkg::CMD_CLEAR: begin
                count <= '0;
              end
              stbs_pkg::CMD_APPEND: begin
                if (count < DEPTH_CNT) begin
                  count <= count + CW'(1);
                end
              end
              default: begin
                target <= $signed(head.word.value);
                upper  <= (head.word.command == stbs_pkg::CMD_UPPER);
                lo     <= '0;
                hi     <= count;
                state  <= (count == '0) ? ST_HOLD : ST_SEARCH;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          lo <= lo_step;
          hi <= hi_step;
          if (!more) begin
            state <= slot_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The entry count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count above depth");

  // A running search always has a nonempty window inside the used entries.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((lo < hi) && (hi <= count)))
    else $error("search window empty or beyond entry count");

  // No queued word is consumed while a search or its result is pending.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE))
    else $error("queue popped during a search");

  // A loaded result never points past the entry count.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    load_search |-> (lo_step <= count))
    else $error("result beyond entry count");

endmodule

@@ src/sorted_table_bound_search.sv @@
// Clear and append words are executed as the back end takes them from the queue.
// A query runs a binary search for the lower or upper bound (no probe on an empty
// table), one table probe per cycle through the registered table RAM.
// A two-word queue lets new words be accepted while a search runs.
// Reset (rst, synchronous, active high) empties the queue and the table count.
module sorted_table_bound_search #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [stbs_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
  input  logic [stbs_pkg::CMD_W-1:0]          s_tuser,   // [1:0] command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [stbs_pkg::OUT_TDATA_W-1:0]    m_tdata    // [10:0] position, rest zero
);

  stbs_pkg::stbs_head_t head;
  logic pop;
  logic [stbs_pkg::POS_W-1:0] position;

  // Front end: accepts words into the command queue.
  stbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  // Back end: keeps the table and runs the searches.
  stbs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_position (position)
  );

  assign m_tdata = stbs_pkg::OUT_TDATA_W'(position);

endmodule
